/* rtl/mstt_pkg.sv */
// types and constants for the multi-slot periodic timer table
// shared by mstt_out_reg and the top level; no dependencies
package mstt_pkg;

	localparam int SLOT_W = 4;
	localparam int TICK_W = 32;
	localparam int CMD_W  = 3;
	localparam int KIND_W = 2;

	// command codes carried on the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK        = 3'd0,
		CMD_START       = 3'd1,
		CMD_STOP        = 3'd2,
		CMD_CANCEL      = 3'd3,
		CMD_STOP_REPEAT = 3'd4,
		CMD_SUSPEND     = 3'd5,
		CMD_RESUME      = 3'd6
	} cmd_t;

	// result kinds carried on the output tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_START_ANS = 2'd0,
		KIND_FIRED     = 2'd1,
		KIND_DONE      = 2'd2
	} kind_t;

	// one result transaction
	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic              full;
		logic [TICK_W-1:0] tick;
		logic              last;
	} result_t;

	// one slot entry held in the slot memory
	typedef struct packed {
		logic [TICK_W-1:0] deadline;
		logic [TICK_W-1:0] reload;
		logic              rep;
		logic              hld;
		logic              sil;
	} entry_t;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DONE   = 6'b000100,
		ST_START  = 6'b001000,
		ST_CMD_RD = 6'b010000,
		ST_CMD_WR = 6'b100000
	} state_t;

endpackage

/* rtl/mstt_out_reg.sv */
// output register for result transactions of the timer table
// depends on mstt_pkg for result_t
module mstt_out_reg import mstt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    free,
	output logic    valid,
	input  logic    ready,
	output result_t dout
);

	logic    valid_q;
	result_t data_q;

	// register can take a new result when empty or being drained
	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign dout  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

endmodule

/* rtl/multi_slot_periodic_timer_table_unit.sv */
// timer table: a tick scans the slots one per cycle (accept, a read of
// each slot plus one final evaluate, done); start answers from its own
// state, the other commands read the slot, then modify-write it; the
// one slot memory read per cycle sets the scan rate, and a stalled
// output holds the scan; reset clears busy bits and the tick counter,
// the slot memory itself is not cleared
module multi_slot_periodic_timer_table_unit import mstt_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // slot_id[3:0], period[35:4], periodic[36], zero pad
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // slot_out[3:0], full_res[4], tick_now[36:5], zero pad
	output logic [1:0]  m_tuser,  // kind[1:0]
	output logic        m_tlast
);

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [SLOT_W-1:0]   sid_q;
	logic [TICK_W-1:0]   period_q;
	logic                periodic_q;
	logic [TICK_W-1:0]   tick_q;
	logic [NUM_SLOTS-1:0] busy_q;

	logic [CW-1:0]       scan_idx_q;
	logic                ev_valid_s1;
	logic [AW-1:0]       ev_idx_s1;
	entry_t              rdata_s1;

	entry_t              mem [NUM_SLOTS];

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;

	logic                out_free;
	logic                out_push;
	result_t             out_din;
	result_t             out_dout;

	logic                in_acc;
	logic [IW-1:0]       sid_w;
	logic                sid_hit;
	logic [AW-1:0]       sid_addr;
	logic                sid_busy;

	logic                ev_fire;
	logic                ev_report;
	logic                scan_more;
	logic                scan_adv;

	logic                free_found;
	logic [AW-1:0]       free_idx;
	entry_t              cmd_entry;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// target slot decode
	assign sid_w    = IW'(sid_q);
	assign sid_hit  = sid_w < IW'(NUM_SLOTS);
	assign sid_addr = sid_w[AW-1:0];
	assign sid_busy = sid_hit && busy_q[sid_addr];

	// scan evaluate stage
	assign ev_fire   = ev_valid_s1 && busy_q[ev_idx_s1] && !rdata_s1.hld &&
	                   (rdata_s1.deadline <= tick_q);
	assign ev_report = ev_fire && !rdata_s1.sil;
	assign scan_more = scan_idx_q < CW'(NUM_SLOTS);
	assign scan_adv  = (state_q == ST_SCAN) && !(ev_report && !out_free);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// single-slot command modify
	always_comb begin
		cmd_entry = rdata_s1;
		unique case (cmd_q)
			CMD_CANCEL: begin
				cmd_entry.sil      = 1'b1;
				cmd_entry.hld      = 1'b0;
				cmd_entry.rep      = 1'b0;
				cmd_entry.deadline = '0;
			end
			CMD_STOP_REPEAT: cmd_entry.rep = 1'b0;
			CMD_SUSPEND:     cmd_entry.hld = 1'b1;
			CMD_RESUME: begin
				cmd_entry.hld      = 1'b0;
				cmd_entry.deadline = '0;
			end
			default: cmd_entry = rdata_s1;
		endcase
	end

	// memory port control and result selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rdata_s1;
		ram_re    = 1'b0;
		ram_raddr = scan_idx_q[AW-1:0];
		out_push  = 1'b0;
		out_din   = '{kind: KIND_DONE, slot: sid_q, full: 1'b0, tick: tick_q, last: 1'b1};
		unique case (state_q)
			ST_SCAN: begin
				ram_re = scan_adv && scan_more;
				if (scan_adv && ev_fire && rdata_s1.rep) begin
					ram_we             = 1'b1;
					ram_waddr          = ev_idx_s1;
					ram_wdata.deadline = tick_q + rdata_s1.reload;
				end
				out_push = scan_adv && ev_report;
				out_din  = '{kind: KIND_FIRED, slot: SLOT_W'(ev_idx_s1), full: 1'b0,
				             tick: tick_q, last: 1'b0};
			end
			ST_DONE: begin
				out_push = out_free;
				out_din  = '{kind: KIND_DONE, slot: '0, full: 1'b0,
				             tick: tick_q + 1'b1, last: 1'b1};
			end
			ST_START: begin
				out_push  = out_free;
				ram_we    = out_free && free_found;
				ram_waddr = free_idx;
				ram_wdata = '{deadline: tick_q + period_q, reload: period_q,
				              rep: periodic_q, hld: 1'b0, sil: 1'b0};
				out_din   = '{kind: KIND_START_ANS,
				              slot: free_found ? SLOT_W'(free_idx) : '0,
				              full: !free_found, tick: tick_q, last: 1'b1};
			end
			ST_CMD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = sid_addr;
			end
			ST_CMD_WR: begin
				out_push  = out_free;
				ram_we    = out_free && sid_busy && (cmd_q != CMD_STOP);
				ram_waddr = sid_addr;
				ram_wdata = cmd_entry;
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (ram_we) begin
			mem[ram_waddr] <= ram_wdata;
		end
		if (ram_re) begin
			rdata_s1 <= mem[ram_raddr];
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q      <= cmd_t'(s_tuser);
			sid_q      <= s_tdata[3:0];
			period_q   <= s_tdata[35:4];
			periodic_q <= s_tdata[36];
		end
	end

	// scan evaluate slot index
	always_ff @(posedge clk) begin
		if (ram_re && (state_q == ST_SCAN)) begin
			ev_idx_s1 <= scan_idx_q[AW-1:0];
		end
	end

	// sequencer, scan counter, tick counter, busy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			ev_valid_s1 <= 1'b0;
			tick_q      <= '0;
			busy_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (cmd_t'(s_tuser))
							CMD_TICK: begin
								state_q    <= ST_SCAN;
								scan_idx_q <= '0;
							end
							CMD_START: state_q <= ST_START;
							default:   state_q <= ST_CMD_RD;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_adv) begin
						ev_valid_s1 <= scan_more;
						if (scan_more) begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
						if (ev_fire && !rdata_s1.rep) begin
							busy_q[ev_idx_s1] <= 1'b0;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						tick_q  <= tick_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_START: begin
					if (out_free) begin
						if (free_found) begin
							busy_q[free_idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CMD_RD: begin
					state_q <= ST_CMD_WR;
				end
				ST_CMD_WR: begin
					if (out_free) begin
						if (sid_busy && (cmd_q == CMD_STOP)) begin
							busy_q[sid_addr] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	mstt_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_din),
		.free   (out_free),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.dout   (out_dout)
	);

	assign m_tdata = {3'b000, out_dout.tick, out_dout.full, out_dout.slot};
	assign m_tuser = out_dout.kind;
	assign m_tlast = out_dout.last;

endmodule

/* test/tb.sv */
// testbench for the multi-slot periodic timer table unit
// drives commands on the input stream and checks every result against an in-bench predictor
// depends on mstt_pkg and multi_slot_periodic_timer_table_unit
`timescale 1ns / 100ps

module tb import mstt_pkg::*;;

	localparam int NSLOTS = 16;
	localparam int RUN_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 290;
	// code outside the command set, answered with a plain done
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	// tracks the slot table and the results each command should produce
	class timer_table_tracker;
		bit          busy [NSLOTS];
		logic [31:0] due_at [NSLOTS];
		logic [31:0] reload [NSLOTS];
		bit          rep [NSLOTS];
		bit          hold [NSLOTS];
		bit          mute [NSLOTS];
		logic [31:0] ticks;
		result_t     pending_results [$];
		int          mismatches;

		function new();
			ticks = '0;
			mismatches = 0;
			foreach (busy[i]) busy[i] = 1'b0;
		endfunction

		function void queue_result(kind_t k, logic [3:0] s, logic f, logic [31:0] t, logic l);
			result_t r;
			r.kind = k;
			r.slot = s;
			r.full = f;
			r.tick = t;
			r.last = l;
			pending_results.push_back(r);
		endfunction

		// one accepted command: update the table and queue its results
		function void note_command(logic [2:0] cmd, logic [3:0] sid, logic [31:0] period,
				logic periodic);
			logic [31:0] now;
			bit placed;
			now = ticks;
			placed = 1'b0;
			case (cmd)
			CMD_TICK: begin
				// due slots in ascending order, silenced ones expire quietly
				for (int i = 0; i < NSLOTS; i++) begin
					if (busy[i] && !hold[i] && due_at[i] <= now) begin
						if (!mute[i])
							queue_result(KIND_FIRED, 4'(i), 1'b0, now, 1'b0);
						if (!rep[i])
							busy[i] = 1'b0;
						else
							due_at[i] = now + reload[i];
					end
				end
				ticks = now + 32'd1;
				queue_result(KIND_DONE, 4'd0, 1'b0, ticks, 1'b1);
			end
			CMD_START: begin
				for (int i = 0; i < NSLOTS; i++) begin
					if (!placed && !busy[i]) begin
						placed = 1'b1;
						busy[i] = 1'b1;
						due_at[i] = now + period;
						reload[i] = period;
						rep[i] = periodic;
						hold[i] = 1'b0;
						mute[i] = 1'b0;
						queue_result(KIND_START_ANS, 4'(i), 1'b0, now, 1'b1);
					end
				end
				if (!placed)
					queue_result(KIND_START_ANS, 4'd0, 1'b1, now, 1'b1);
			end
			default: begin
				// slot commands act only on a busy slot, all of them answer done
				if (busy[sid]) begin
					case (cmd)
					CMD_STOP: busy[sid] = 1'b0;
					CMD_CANCEL: begin
						mute[sid] = 1'b1;
						hold[sid] = 1'b0;
						rep[sid] = 1'b0;
						due_at[sid] = '0;
					end
					CMD_STOP_REPEAT: rep[sid] = 1'b0;
					CMD_SUSPEND: hold[sid] = 1'b1;
					CMD_RESUME: begin
						hold[sid] = 1'b0;
						due_at[sid] = '0;
					end
					default: ;
					endcase
				end
				queue_result(KIND_DONE, sid, 1'b0, now, 1'b1);
			end
			endcase
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d tick %0d", got.kind, got.slot,
					got.tick);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.slot !== want.slot) begin
				$error("slot_out: expected %0d, got %0d", want.slot, got.slot);
				mismatches++;
			end
			if (got.full !== want.full) begin
				$error("full_res: expected %0b, got %0b", want.full, got.full);
				mismatches++;
			end
			if (got.tick !== want.tick) begin
				$error("tick_now: expected %0d, got %0d", want.tick, got.tick);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // slot_id[3:0], period[35:4], periodic[36], zero pad
	logic [2:0]  s_tuser;   // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // slot_out[3:0], full_res[4], tick_now[36:5], zero pad
	logic [1:0]  m_tuser;   // kind[1:0]
	logic        m_tlast;

	timer_table_tracker timers = new();
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int cycle_cnt = 0;

	multi_slot_periodic_timer_table_unit #(
		.NUM_SLOTS(NSLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// note accepted commands first, then check accepted results
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				timers.note_command(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[36]);
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.slot = m_tdata[3:0];
				got.full = m_tdata[4];
				got.tick = m_tdata[36:5];
				got.last = m_tlast;
				timers.check_result(got);
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 19);
		end
	end

	// offer one command until it is taken, after an optional random gap
	task automatic send_command(input logic [2:0] cmd, input logic [3:0] sid,
			input logic [31:0] period, input logic periodic);
		while (!steady && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, periodic, period, sid};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		logic [2:0]  cmd;
		logic [3:0]  sid;
		logic [31:0] period;
		int          pick;
		int          busy_list [$];

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, wrapped deadline, every slot command, full table
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_START, 4'd0, 32'd0, 1'b0);
		send_command(CMD_START, 4'd0, 32'hFFFF_FFFF, 1'b1);
		send_command(CMD_START, 4'd0, 32'd3, 1'b1);
		send_command(CMD_SUSPEND, 4'd2, 32'd0, 1'b0);
		send_command(CMD_CANCEL, 4'd0, 32'd0, 1'b0);
		send_command(CMD_STOP_REPEAT, 4'd1, 32'd0, 1'b0);
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_RESUME, 4'd2, 32'd0, 1'b0);
		send_command(CMD_UNUSED, 4'd15, 32'd0, 1'b0);
		send_command(CMD_STOP, 4'd15, 32'd0, 1'b0);
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		for (int n = 0; n < NSLOTS; n++)
			send_command(CMD_START, 4'd0, 32'd0, n[0]);
		send_command(CMD_RESUME, 4'd2, 32'd0, 1'b0);
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_STOP, 4'd15, 32'd0, 1'b0);

		// random: mostly ticks and starts with short periods, commands aimed at busy slots
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 100 && n < 170);
			if (n == 220)
				hold_req = 1'b1;
			pick = $urandom_range(99);
			sid = 4'($urandom_range(NSLOTS - 1));
			period = '0;
			if (pick < 45) begin
				cmd = CMD_TICK;
			end else if (pick < 70) begin
				cmd = CMD_START;
				pick = $urandom_range(99);
				if (pick < 70)
					period = $urandom_range(12);
				else if (pick < 90)
					period = $urandom_range(100);
				else
					period = $urandom;
			end else if (pick < 71) begin
				cmd = CMD_UNUSED;
			end else begin
				cmd = 3'($urandom_range(CMD_STOP, CMD_RESUME));
				busy_list.delete();
				foreach (timers.busy[i])
					if (timers.busy[i])
						busy_list.push_back(i);
				if (busy_list.size() != 0 && $urandom_range(99) < 85)
					sid = 4'(busy_list[$urandom_range(busy_list.size() - 1)]);
			end
			send_command(cmd, sid, period, 1'($urandom_range(1)));
		end
		s_tvalid <= 1'b0;

		// drain, then allow for the scan latency
		while (timers.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (timers.mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

/* multi_slot_periodic_timer_table_unit.f */
rtl/mstt_pkg.sv
rtl/mstt_out_reg.sv
rtl/multi_slot_periodic_timer_table_unit.sv
test/tb.sv
